FILE: hw/rtl/scwm_pkg.sv
`timescale 1ns / 1ps

package scwm_pkg;

	localparam int MAX_CHARS_DEF = 7;
	localparam int NUM_WORDS_DEF = 5;

	localparam int BYTE_W   = 8;
	localparam int WORD_W   = 56;
	localparam int IDX_W    = 3;
	localparam int CFG_IDX_W = 3;
	localparam int USE_W    = 3;
	localparam int TDATA_IN_W  = 8;
	localparam int TDATA_OUT_W = 8;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_WORD_ZERO    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WORDS_IN_USE = 3'd5;

	localparam logic [BYTE_W-1:0] CHAR_CR  = 8'd13;
	localparam logic [BYTE_W-1:0] CHAR_LF  = 8'd10;
	localparam logic [BYTE_W-1:0] CHAR_NUL = 8'd0;
	localparam logic [BYTE_W-1:0] CHAR_SP  = 8'd32;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] index;
	} match_t;

	function automatic logic is_delim(input logic [BYTE_W-1:0] c);
		return (c == CHAR_CR) || (c == CHAR_LF) || (c == CHAR_NUL) || (c == CHAR_SP);
	endfunction

endpackage

FILE: hw/rtl/scwm_token.sv
`timescale 1ns / 1ps

module scwm_token #(
	parameter int MAX_CHARS = scwm_pkg::MAX_CHARS_DEF,
	parameter int LEN_W     = $clog2(MAX_CHARS + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 byte_valid,
	input  logic [scwm_pkg::BYTE_W-1:0]          rx_byte,
	output logic [MAX_CHARS*scwm_pkg::BYTE_W-1:0] token_chars,
	output logic [LEN_W-1:0]                     token_len,
	output logic                                 compare
);

	logic [MAX_CHARS*scwm_pkg::BYTE_W-1:0] chars_q;
	logic [LEN_W-1:0]                      len_q;
	logic                                  ovf_q;
	logic                                  delim;

	assign delim       = scwm_pkg::is_delim(rx_byte);
	assign token_chars = chars_q;
	assign token_len   = len_q;
	assign compare     = byte_valid && delim && (len_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_q <= '0;
			len_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (byte_valid) begin
			if (delim) begin
				// drop the token whether or not it matched
				chars_q <= '0;
				len_q   <= '0;
				ovf_q   <= 1'b0;
			end else if (!ovf_q) begin
				if (len_q == LEN_W'(MAX_CHARS)) begin
					chars_q <= '0;
					len_q   <= '0;
					ovf_q   <= 1'b1;
				end else begin
					for (int i = 0; i < MAX_CHARS; i++) begin
						if (len_q == LEN_W'(i)) begin
							chars_q[i*scwm_pkg::BYTE_W +: scwm_pkg::BYTE_W] <= rx_byte;
						end
					end
					len_q <= len_q + LEN_W'(1);
				end
			end
		end
	end

endmodule

FILE: hw/rtl/scwm_match.sv
`timescale 1ns / 1ps

module scwm_match #(
	parameter int MAX_CHARS = scwm_pkg::MAX_CHARS_DEF,
	parameter int NUM_WORDS = scwm_pkg::NUM_WORDS_DEF,
	parameter int LEN_W     = $clog2(MAX_CHARS + 1)
) (
	input  logic [MAX_CHARS*scwm_pkg::BYTE_W-1:0]       token_chars,
	input  logic [LEN_W-1:0]                            token_len,
	input  logic [NUM_WORDS-1:0][scwm_pkg::WORD_W-1:0]  words,
	input  logic [scwm_pkg::USE_W-1:0]                  words_in_use,
	output scwm_pkg::match_t                            result
);

	logic [63:0]          tok64;
	logic [NUM_WORDS-1:0] word_hit;

	assign tok64 = 64'(token_chars);

	// Token bytes past the length are zero, so byte len checks the word terminator.
	// Byte 7 of a word is always zero: an eight-character token never matches.
	always_comb begin
		logic [63:0] w64;
		logic        ok;
		for (int w = 0; w < NUM_WORDS; w++) begin
			w64 = 64'(words[w]);
			ok  = (scwm_pkg::USE_W'(w) < words_in_use);
			for (int i = 0; i < 8; i++) begin
				if ((i <= int'(token_len)) &&
				    (w64[i*8 +: 8] != tok64[i*8 +: 8])) begin
					ok = 1'b0;
				end
			end
			word_hit[w] = ok;
		end
	end

	always_comb begin
		result.hit   = |word_hit;
		result.index = '0;
		for (int w = NUM_WORDS - 1; w >= 0; w--) begin
			if (word_hit[w]) begin
				result.index = scwm_pkg::IDX_W'(w);
			end
		end
	end

endmodule

FILE: hw/rtl/serial_command_word_matcher_unit.sv
`timescale 1ns / 1ps

// Serial command word matcher. Takes one received character per beat on the
// s_ side; non-delimiter characters (anything but CR, LF, NUL, space) build a
// token of up to MAX_CHARS characters, and a longer token is dropped until the
// next delimiter. On a delimiter a non-empty token is compared with the first
// words_in_use command words and the lowest matching index leaves on the m_
// side; no match gives no beat. One beat per cycle is sustained unless the m_
// side holds a result back with m_tready low: a byte sits in the input
// register, where the token update and all word compares run in parallel,
// and the result lands in the output register. Command words
// hold character i in byte i, ending at the first zero byte; write the
// registers only while the block is idle.
module serial_command_word_matcher_unit #(
	parameter int MAX_CHARS = scwm_pkg::MAX_CHARS_DEF,
	parameter int NUM_WORDS = scwm_pkg::NUM_WORDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [scwm_pkg::TDATA_IN_W-1:0]     s_tdata,  // [7:0] rx_byte
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [scwm_pkg::TDATA_OUT_W-1:0]    m_tdata,  // [2:0] command_index
	input  logic                                cfg_we,
	input  logic [scwm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [scwm_pkg::WORD_W-1:0]         cfg_data
);

	localparam int LEN_W = $clog2(MAX_CHARS + 1);

	logic [NUM_WORDS-1:0][scwm_pkg::WORD_W-1:0] words_q;
	logic [scwm_pkg::USE_W-1:0]                 use_q;

	logic                          valid_s1;
	logic [scwm_pkg::BYTE_W-1:0]   byte_s1;
	logic                          advance;

	logic [MAX_CHARS*scwm_pkg::BYTE_W-1:0] token_chars;
	logic [LEN_W-1:0]                      token_len;
	logic                                  compare;
	scwm_pkg::match_t                      match;

	logic                          out_valid_q;
	logic [scwm_pkg::IDX_W-1:0]    out_index_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q <= '0;
			use_q   <= '0;
		end else if (cfg_we) begin
			for (int w = 0; w < NUM_WORDS; w++) begin
				if (cfg_index == scwm_pkg::REG_WORD_ZERO + scwm_pkg::CFG_IDX_W'(w)) begin
					words_q[w] <= cfg_data;
				end
			end
			if (cfg_index == scwm_pkg::REG_WORDS_IN_USE) begin
				use_q <= cfg_data[scwm_pkg::USE_W-1:0];
			end
		end
	end

	// Input register: advance when the output register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[scwm_pkg::BYTE_W-1:0];
		end
	end

	scwm_token #(
		.MAX_CHARS(MAX_CHARS),
		.LEN_W    (LEN_W)
	) u_token (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (advance),
		.rx_byte    (byte_s1),
		.token_chars(token_chars),
		.token_len  (token_len),
		.compare    (compare)
	);

	scwm_match #(
		.MAX_CHARS(MAX_CHARS),
		.NUM_WORDS(NUM_WORDS),
		.LEN_W    (LEN_W)
	) u_match (
		.token_chars (token_chars),
		.token_len   (token_len),
		.words       (words_q),
		.words_in_use(use_q),
		.result      (match)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= compare && match.hit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && compare && match.hit) begin
			out_index_q <= match.index;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = scwm_pkg::TDATA_OUT_W'(out_index_q);

endmodule

FILE: tb/serial_command_word_matcher_unit_tb.sv
`timescale 1ns / 1ps

module serial_command_word_matcher_unit_tb;

	import scwm_pkg::*;

	localparam int LIMIT_CYCLES  = 300000;
	localparam int SETTLE_CYCLES = 8;

	// Indexes past the register list; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_HIT} row_kind_e;
	typedef enum int {STYLE_PLAIN, STYLE_DUPES, STYLE_EXTREMES} word_style_e;

	typedef struct packed {
		logic [BYTE_W-1:0] ch;
		row_kind_e         kind;
		logic [IDX_W-1:0]  idx;
	} dir_row_t;

	localparam int DIR_N = 27;

	// Directed words: "GO", "ST" with junk after its end, "GO" again, empty, "ABCDEFG"
	localparam logic [WORD_W-1:0] DIR_WORDS [NUM_WORDS_DEF] = '{
		56'h0000_0000_0000_4F47,
		56'h5A5A_5A5A_0054_53,
		56'h0000_0000_0000_4F47,
		56'h0,
		56'h4746_4544_4342_41
	};

	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		'{CHAR_CR,  ROW_NONE, 3'd0},
		'{"G",      ROW_PRED, 3'd0},
		'{"O",      ROW_PRED, 3'd0},
		'{CHAR_SP,  ROW_HIT,  3'd0},
		'{"S",      ROW_PRED, 3'd0},
		'{"T",      ROW_PRED, 3'd0},
		'{CHAR_LF,  ROW_HIT,  3'd1},
		'{"A",      ROW_PRED, 3'd0},
		'{"B",      ROW_PRED, 3'd0},
		'{"C",      ROW_PRED, 3'd0},
		'{"D",      ROW_PRED, 3'd0},
		'{"E",      ROW_PRED, 3'd0},
		'{"F",      ROW_PRED, 3'd0},
		'{"G",      ROW_PRED, 3'd0},
		'{CHAR_NUL, ROW_HIT,  3'd4},
		'{8'hFF,    ROW_PRED, 3'd0},
		'{8'hFF,    ROW_PRED, 3'd0},
		'{8'hFF,    ROW_PRED, 3'd0},
		'{8'hFF,    ROW_PRED, 3'd0},
		'{8'hFF,    ROW_PRED, 3'd0},
		'{8'hFF,    ROW_PRED, 3'd0},
		'{8'hFF,    ROW_PRED, 3'd0},
		'{8'h01,    ROW_PRED, 3'd0},
		'{"G",      ROW_PRED, 3'd0},
		'{CHAR_SP,  ROW_NONE, 3'd0},
		'{"X",      ROW_PRED, 3'd0},
		'{CHAR_CR,  ROW_PRED, 3'd0}
	};

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata   = '0;  // [7:0] rx_byte
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;         // [2:0] command_index
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [WORD_W-1:0]      cfg_data  = '0;

	serial_command_word_matcher_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Matcher state and registers as the block should hold them
	logic [WORD_W-1:0]  cmd_words [NUM_WORDS_DEF];
	logic [USE_W-1:0]   words_used;
	logic [63:0]        tok_chars;
	int                 tok_len;
	bit                 tok_ovf;

	logic [IDX_W-1:0]   expected_cmds [$];
	row_kind_e          exp_kind  = ROW_PRED;
	logic [IDX_W-1:0]   exp_typed = '0;

	int errors        = 0;
	int bytes_sent    = 0;
	int matches_seen  = 0;
	int settings_used = 0;
	int cycle_cnt     = 0;
	int stall_left    = 0;
	bit idle_on       = 1'b1;

	bit                     mon_hit;
	logic [IDX_W-1:0]       mon_idx;
	logic [IDX_W-1:0]       mon_want;
	logic [TDATA_OUT_W-1:0] mon_beat;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic bit is_separator(input logic [BYTE_W-1:0] c);
		return c == CHAR_CR || c == CHAR_LF || c == CHAR_NUL || c == CHAR_SP;
	endfunction

	function automatic logic [BYTE_W-1:0] word_char(input logic [WORD_W-1:0] w, input int i);
		if (i >= 7)
			return '0;
		return w[8*i +: 8];
	endfunction

	function automatic bit token_equals(input logic [WORD_W-1:0] w);
		int i;
		for (i = 0; i < tok_len; i++)
			if (word_char(w, i) != tok_chars[8*i +: 8])
				return 1'b0;
		return word_char(w, tok_len) == 8'h00;
	endfunction

	function automatic void step_matcher(input logic [BYTE_W-1:0] c, output bit hit,
			output logic [IDX_W-1:0] idx);
		int n;
		int k;
		hit = 1'b0;
		idx = '0;
		if (is_separator(c)) begin
			tok_ovf = 1'b0;
			if (tok_len > 0) begin
				n = (words_used > NUM_WORDS_DEF) ? NUM_WORDS_DEF : int'(words_used);
				for (k = 0; k < n && !hit; k++) begin
					if (token_equals(cmd_words[k])) begin
						hit = 1'b1;
						idx = IDX_W'(k);
					end
				end
				tok_chars = '0;
				tok_len   = 0;
			end
		end else if (!tok_ovf) begin
			if (tok_len >= MAX_CHARS_DEF) begin
				tok_chars = '0;
				tok_len   = 0;
				tok_ovf   = 1'b1;
			end else begin
				tok_chars[8*tok_len +: 8] = c;
				tok_len++;
			end
		end
	endfunction

	function automatic logic [BYTE_W-1:0] rand_char();
		logic [BYTE_W-1:0] c;
		c = BYTE_W'($urandom_range(1, 255));
		while (is_separator(c))
			c = BYTE_W'($urandom_range(1, 255));
		return c;
	endfunction

	function automatic logic [BYTE_W-1:0] rand_delim();
		case ($urandom_range(0, 3))
			0: return CHAR_CR;
			1: return CHAR_LF;
			2: return CHAR_NUL;
			default: return CHAR_SP;
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] rand_word(input bit junk_tail);
		logic [WORD_W-1:0] w;
		int len;
		int k;
		w = '0;
		len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7);
		for (k = 0; k < len; k++)
			w[8*k +: 8] = rand_char();
		if (junk_tail)
			for (k = len + 1; k < 7; k++)
				w[8*k +: 8] = BYTE_W'($urandom);
		return w;
	endfunction

	// Check the result beat, then predict for the byte taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_cmds.size() == 0) begin
					$error("command_index: expected no beat, got %0d", m_tdata);
					errors++;
				end else begin
					mon_want = expected_cmds.pop_front();
					mon_beat = '0;
					mon_beat[IDX_W-1:0] = mon_want;
					if (m_tdata !== mon_beat) begin
						$error("command_index: expected %0d, got %0d", mon_beat, m_tdata);
						errors++;
					end
					matches_seen++;
				end
			end
			if (s_tvalid && s_tready) begin
				step_matcher(s_tdata, mon_hit, mon_idx);
				case (exp_kind)
					ROW_PRED: if (mon_hit) expected_cmds.push_back(mon_idx);
					ROW_HIT:  expected_cmds.push_back(exp_typed);
					default: ;
				endcase
			end
		end
	end

	// Receiver back-pressure in bursts
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 8) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		while (cycle_cnt < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("serial_command_word_matcher_unit_tb: done, errors");
		$finish;
	end

	task automatic send_byte(input logic [BYTE_W-1:0] c, input row_kind_e kind,
			input logic [IDX_W-1:0] idx);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		s_tvalid  <= 1'b1;
		s_tdata   <= c;
		exp_kind  = kind;
		exp_typed = idx;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		bytes_sent++;
	endtask

	// Stop sending and let every expected beat arrive, then let the pipeline empty
	task automatic hold_off();
		s_tvalid <= 1'b0;
		while (expected_cmds.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		if (int'(idx) < NUM_WORDS_DEF)
			cmd_words[idx] = data;
		else if (idx == REG_WORDS_IN_USE)
			words_used = data[USE_W-1:0];
		@(negedge clk);
	endtask

	task automatic send_sequence();
		logic [WORD_W-1:0] w;
		int r;
		int n;
		int k;
		w = cmd_words[$urandom_range(0, NUM_WORDS_DEF - 1)];
		n = 0;
		while (n < 7 && w[8*n +: 8] != 8'h00)
			n++;
		r = $urandom_range(0, 99);
		if (r < 72) begin
			// a configured word, or it with its last char replaced or one char longer
			if (r >= 60 && n > 1 && $urandom_range(0, 1) == 1)
				n--;
			for (k = 0; k < n; k++)
				send_byte(w[8*k +: 8], ROW_PRED, '0);
			if (n == 0 || r >= 60)
				send_byte(rand_char(), ROW_PRED, '0);
			send_byte(rand_delim(), ROW_PRED, '0);
		end else if (r < 84) begin
			repeat ($urandom_range(8, 12)) send_byte(rand_char(), ROW_PRED, '0);
			send_byte(rand_delim(), ROW_PRED, '0);
		end else begin
			repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom), ROW_PRED, '0);
		end
		if ($urandom_range(0, 7) == 0)
			send_byte(rand_delim(), ROW_PRED, '0);
	endtask

	task automatic run_phase(input int n_items, input int use_n, input word_style_e style);
		logic [WORD_W-1:0] w [NUM_WORDS_DEF];
		logic [WORD_W-1:0] use_data;
		int k;
		int end_cnt;
		hold_off();
		for (k = 0; k < NUM_WORDS_DEF; k++)
			w[k] = rand_word(style == STYLE_DUPES);
		if (style == STYLE_DUPES) begin
			w[2] = w[0];
			w[4] = w[1];
		end else if (style == STYLE_EXTREMES) begin
			w[0] = {7{8'hFF}};
			w[1] = '0;
			w[2] = {48'h0, rand_char()};
			w[3] = {{6{8'hFF}}, 8'h00};
		end
		use_data = WORD_W'(use_n);
		if (style == STYLE_EXTREMES)
			use_data[WORD_W-1:USE_W] = (WORD_W-USE_W)'({$urandom, $urandom});
		for (k = 0; k < NUM_WORDS_DEF; k++)
			write_reg(CFG_IDX_W'(int'(REG_WORD_ZERO) + k), w[k]);
		write_reg(REG_WORDS_IN_USE, use_data);
		write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI,
			WORD_W'({$urandom, $urandom}));
		cfg_we <= 1'b0;
		settings_used++;
		end_cnt = bytes_sent + n_items;
		while (bytes_sent < end_cnt) begin
			if ($urandom_range(0, 149) == 0)
				hold_off();
			send_sequence();
		end
	endtask

	initial begin
		int k;
		for (k = 0; k < NUM_WORDS_DEF; k++)
			cmd_words[k] = '0;
		words_used = '0;
		tok_chars  = '0;
		tok_len    = 0;
		tok_ovf    = 1'b0;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// First beat tests the cleared state: a lone delimiter gives nothing
		for (k = 0; k < NUM_WORDS_DEF; k++)
			write_reg(CFG_IDX_W'(int'(REG_WORD_ZERO) + k), DIR_WORDS[k]);
		write_reg(REG_WORDS_IN_USE, WORD_W'(7));
		write_reg(REG_UNUSED_LO, '1);
		write_reg(REG_UNUSED_HI, '1);
		cfg_we <= 1'b0;
		settings_used++;
		for (k = 0; k < DIR_N; k++)
			send_byte(DIR_ROWS[k].ch, DIR_ROWS[k].kind, DIR_ROWS[k].idx);

		run_phase(340, 5, STYLE_PLAIN);
		run_phase(150, 0, STYLE_PLAIN);
		run_phase(340, 7, STYLE_DUPES);
		run_phase(300, 3, STYLE_EXTREMES);
		run_phase(300, 1, STYLE_PLAIN);
		idle_on = 1'b0;
		run_phase(420, $urandom_range(2, 6), STYLE_PLAIN);

		hold_off();
		$display("Sent %0d bytes over %0d register settings; %0d command beats checked.",
			bytes_sent, settings_used, matches_seen);
		if (errors == 0)
			$display("serial_command_word_matcher_unit_tb: done, clean");
		else
			$display("serial_command_word_matcher_unit_tb: done, errors");
		$finish;
	end

endmodule
